// ===== rtl/arpc_pkg.sv =====
package arpc_pkg;

  localparam int unsigned CacheEntries = 8;

  localparam int unsigned IpW  = 32;
  localparam int unsigned MacW = 48;
  localparam int unsigned OpcW = 16;

  localparam logic KIND_ARP     = 1'b0;
  localparam logic KIND_RESOLVE = 1'b1;

  localparam logic [OpcW-1:0] OPC_REQUEST = 16'd1;

  localparam logic [1:0] RES_REPLY = 2'd0;
  localparam logic [1:0] RES_HIT   = 2'd1;
  localparam logic [1:0] RES_MISS  = 2'd2;

  localparam logic [1:0] REG_OWN_IP  = 2'd0;
  localparam logic [1:0] REG_MASK    = 2'd1;
  localparam logic [1:0] REG_NET     = 2'd2;
  localparam logic [1:0] REG_GATEWAY = 2'd3;

  // write request broadcast to every cell
  typedef struct packed {
    logic            en;
    logic            any_hit;
    logic [IpW-1:0]  ip;
    logic [MacW-1:0] mac;
  } arpc_wr_t;

  // lookup outcome from the chain
  typedef struct packed {
    logic            hit;
    logic [MacW-1:0] mac;
  } arpc_res_t;

endpackage

// ===== rtl/arpc_cell.sv =====
module arpc_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [arpc_pkg::IpW-1:0]        key_i,
  input  arpc_pkg::arpc_wr_t              wr_i,
  input  logic                            tok_rst_i,
  input  logic                            hit_i,
  input  logic                            tok_i,
  output logic                            hit_o,
  output logic                            tok_o,
  output logic                            first_o,
  output logic [arpc_pkg::MacW-1:0]       mac_o
);
  import arpc_pkg::*;

  logic [IpW-1:0]  ip_q;
  logic [MacW-1:0] mac_q;
  logic            match_q;
  logic            tok_q, tok_d;
  logic            wr_here;

  assign first_o = match_q & ~hit_i;
  assign hit_o   = hit_i | match_q;
  assign tok_o   = tok_q;
  assign mac_o   = first_o ? mac_q : '0;

  assign wr_here = wr_i.en & (wr_i.any_hit ? first_o : tok_q);
  assign tok_d   = (wr_i.en & ~wr_i.any_hit) ? tok_i : tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_q    <= '0;
      mac_q   <= '0;
      match_q <= 1'b0;
      tok_q   <= tok_rst_i;
    end else begin
      match_q <= (ip_q == key_i);
      tok_q   <= tok_d;
      if (wr_here) begin
        ip_q  <= wr_i.ip;
        mac_q <= wr_i.mac;
      end
    end
  end

endmodule

// ===== rtl/arpc_chain.sv =====
module arpc_chain (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [arpc_pkg::IpW-1:0]   key_i,
  input  arpc_pkg::arpc_wr_t         wr_i,
  output arpc_pkg::arpc_res_t        res_o
);
  import arpc_pkg::*;

  logic [CacheEntries:0]   hit;
  logic [CacheEntries-1:0] tok;
  logic [CacheEntries-1:0] first;
  logic [MacW-1:0]         mac [CacheEntries];
  logic [MacW-1:0]         mac_or;

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CacheEntries; i++) begin : g_cell
    arpc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .key_i     (key_i),
      .wr_i      (wr_i),
      .tok_rst_i (i == 0),
      .hit_i     (hit[i]),
      .tok_i     (tok[(i + CacheEntries - 1) % CacheEntries]),
      .hit_o     (hit[i+1]),
      .tok_o     (tok[i]),
      .first_o   (first[i]),
      .mac_o     (mac[i])
    );
  end

  always_comb begin
    mac_or = '0;
    for (int i = 0; i < CacheEntries; i++) begin
      mac_or = mac_or | mac[i];
    end
  end

  assign res_o.hit = hit[CacheEntries];
  assign res_o.mac = mac_or;

  a_tok_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(tok))
    else $error("victim token lost or duplicated");
  a_first_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(first))
    else $error("more than one first match");
  a_hit_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
      hit[CacheEntries] == (first != '0))
    else $error("hit flag disagrees with match vector");

endmodule

// ===== rtl/arp_cache_responder_unit.sv =====
// An accepted item's key is registered into the cell chain's match registers as the
// FSM enters decode; decode repeats the search for the gateway on an off-subnet
// resolve miss, waits out any output stall and registers the result. A new item is taken only in idle.
// Reset: asynchronous, active low; clears the configuration, FSM and output-valid
// registers and the cache entries, and puts the victim token on entry 0.
module arp_cache_responder_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // s_axis_tdata: arp_opcode[15:0], sender_ip[47:16], sender_mac[95:48],
  //               target_ip[127:96], resolve_ip[159:128]
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // kind
  // m_axis_tdata: peer_mac[47:0], peer_ip[79:48]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // result_kind
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import arpc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DEC  = 1'b1;

  logic [IpW-1:0] own_ip_q, mask_q, net_q, gw_ip_q;

  logic            state_q, state_d;
  logic            gw_q, gw_d;
  logic            kind_q;
  logic [OpcW-1:0] opc_q;
  logic [IpW-1:0]  sip_q, tip_q, rip_q;
  logic [MacW-1:0] smac_q;
  logic [IpW-1:0]  key_q, key_bus;

  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_kind_q, out_kind_d;
  logic [MacW-1:0] out_mac_q, out_mac_d;
  logic [IpW-1:0]  out_ip_q, out_ip_d;

  logic      in_acc, out_free, retry, wr_en;
  arpc_wr_t  wr;
  arpc_res_t res;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
      mask_q   <= '0;
      net_q    <= '0;
      gw_ip_q  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_OWN_IP:  own_ip_q <= pwdata;
        REG_MASK:    mask_q   <= pwdata;
        REG_NET:     net_q    <= pwdata;
        REG_GATEWAY: gw_ip_q  <= pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_OWN_IP:  prdata = own_ip_q;
      REG_MASK:    prdata = mask_q;
      REG_NET:     prdata = net_q;
      REG_GATEWAY: prdata = gw_ip_q;
      default:     prdata = '0;
    endcase
  end

  // datapath
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;

  assign retry = (state_q == ST_DEC) && (kind_q == KIND_RESOLVE) && !res.hit && !gw_q
                 && ((rip_q & mask_q) != net_q);

  always_comb begin
    priority if (state_q == ST_IDLE) begin
      key_bus = (s_axis_tuser == KIND_RESOLVE) ? s_axis_tdata[159:128] : s_axis_tdata[47:16];
    end else if (retry) begin
      key_bus = gw_ip_q;
    end else begin
      key_bus = key_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    gw_d        = gw_q;
    wr_en       = 1'b0;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_kind_d  = out_kind_q;
    out_mac_d   = out_mac_q;
    out_ip_d    = out_ip_q;
    unique case (state_q)
      ST_IDLE: begin
        gw_d = 1'b0;
        if (in_acc) state_d = ST_DEC;
      end
      ST_DEC: begin
        if (kind_q == KIND_ARP) begin
          if (tip_q != own_ip_q) begin
            state_d = ST_IDLE;
          end else if (opc_q == OPC_REQUEST) begin
            if (out_free) begin
              wr_en       = 1'b1;
              out_valid_d = 1'b1;
              out_kind_d  = RES_REPLY;
              out_mac_d   = smac_q;
              out_ip_d    = sip_q;
              state_d     = ST_IDLE;
            end
          end else begin
            wr_en   = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (retry) begin
          gw_d = 1'b1;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = res.hit ? RES_HIT : RES_MISS;
          out_mac_d   = res.hit ? res.mac : '0;
          out_ip_d    = key_q;
          gw_d        = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gw_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gw_q        <= gw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_bus;
    out_kind_q <= out_kind_d;
    out_mac_q  <= out_mac_d;
    out_ip_q   <= out_ip_d;
    if (in_acc) begin
      kind_q <= s_axis_tuser;
      opc_q  <= s_axis_tdata[15:0];
      sip_q  <= s_axis_tdata[47:16];
      smac_q <= s_axis_tdata[95:48];
      tip_q  <= s_axis_tdata[127:96];
      rip_q  <= s_axis_tdata[159:128];
    end
  end

  assign wr.en      = wr_en;
  assign wr.any_hit = res.hit;
  assign wr.ip      = sip_q;
  assign wr.mac     = smac_q;

  arpc_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_bus),
    .wr_i   (wr),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {out_ip_q, out_mac_q};

  a_acc_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_acc |=> state_q == ST_DEC)
    else $error("accepted transfer not decoded next cycle");
  a_out_from_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(m_axis_tvalid) |-> $past(state_q == ST_DEC))
    else $error("result raised outside decode");
  a_gw_resolve: assert property (@(posedge clk_i) disable iff (!rst_ni)
      gw_q |-> (state_q == ST_DEC) && (kind_q == KIND_RESOLVE))
    else $error("gateway search outside a resolve");
  a_wr_arp: assert property (@(posedge clk_i) disable iff (!rst_ni)
      wr_en |-> (kind_q == KIND_ARP) && (tip_q == own_ip_q))
    else $error("cache written for a foreign item");

endmodule

// ===== sim/arp_cache_responder_unit_test.sv =====
module arp_cache_responder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import arpc_pkg::*;

  localparam logic [OpcW-1:0] OpcReply = 16'd2;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles = 8;

  typedef struct {
    logic            kind;
    logic [OpcW-1:0] opcode;
    logic [IpW-1:0]  sender_ip;
    logic [MacW-1:0] sender_mac;
    logic [IpW-1:0]  target_ip;
    logic [IpW-1:0]  resolve_ip;
  } arp_item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [MacW-1:0] mac;
    logic [IpW-1:0]  ip;
  } peer_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;   // opcode, sender_ip, sender_mac, target_ip, resolve_ip
  logic         s_axis_tuser = 1'b0; // kind
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [79:0]  m_axis_tdata;        // peer_mac, peer_ip
  logic [1:0]   m_axis_tuser;        // result_kind
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  arp_cache_responder_unit uut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [IpW-1:0]  cfg_own_ip = '0;
  logic [IpW-1:0]  cfg_mask = '0;
  logic [IpW-1:0]  cfg_net = '0;
  logic [IpW-1:0]  cfg_gateway = '0;
  logic [IpW-1:0]  cache_ip [CacheEntries];
  logic [MacW-1:0] cache_mac [CacheEntries];
  int unsigned     victim_slot = 0;

  arp_item_t    arp_items_q [$];
  peer_result_t expected_peers_q [$];
  arp_item_t    cur_item;
  logic [IpW-1:0] addr_pool [12];

  bit          sender_eager = 1'b0;
  bit          sink_eager = 1'b0;
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned n_replies = 0;
  int unsigned n_hits = 0;
  int unsigned n_misses = 0;
  int unsigned n_gateway = 0;
  int unsigned n_settings = 1;
  int unsigned n_errors = 0;
  int unsigned results_seen = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  function automatic int unsigned find_slot(logic [IpW-1:0] ip);
    for (int unsigned i = 0; i < CacheEntries; i++) begin
      if (cache_ip[i] == ip) return i;
    end
    return CacheEntries;
  endfunction

  function automatic void learn_station(logic [IpW-1:0] ip, logic [MacW-1:0] mac);
    int unsigned slot;
    slot = find_slot(ip);
    if (slot == CacheEntries) begin
      slot = victim_slot;
      victim_slot = (victim_slot + 1) % CacheEntries;
    end
    cache_ip[slot] = ip;
    cache_mac[slot] = mac;
  endfunction

  function automatic void predict_arp_outcome(arp_item_t it);
    peer_result_t r;
    int unsigned  slot;
    logic [IpW-1:0] ip;
    if (it.kind == KIND_ARP) begin
      if (it.target_ip != cfg_own_ip) return;
      if (it.opcode == OPC_REQUEST) begin
        r = '{RES_REPLY, it.sender_mac, it.sender_ip};
        expected_peers_q.push_back(r);
      end
      learn_station(it.sender_ip, it.sender_mac);
      return;
    end
    ip = it.resolve_ip;
    slot = find_slot(ip);
    if (slot == CacheEntries && (ip & cfg_mask) != cfg_net) begin
      ip = cfg_gateway;
      slot = find_slot(ip);
      n_gateway++;
    end
    if (slot < CacheEntries) r = '{RES_HIT, cache_mac[slot], ip};
    else r = '{RES_MISS, '0, ip};
    expected_peers_q.push_back(r);
  endfunction

  function automatic logic [MacW-1:0] pick_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[MacW-1:0];
  endfunction

  function automatic logic [IpW-1:0] pick_ip();
    if ($urandom_range(0, 99) < 85) return addr_pool[$urandom_range(0, 11)];
    return $urandom();
  endfunction

  function automatic arp_item_t arp_pkt(logic [OpcW-1:0] opc, logic [IpW-1:0] s_ip,
                                        logic [MacW-1:0] s_mac, logic [IpW-1:0] t_ip);
    arp_item_t it;
    it.kind = KIND_ARP;
    it.opcode = opc;
    it.sender_ip = s_ip;
    it.sender_mac = s_mac;
    it.target_ip = t_ip;
    it.resolve_ip = $urandom();
    return it;
  endfunction

  function automatic arp_item_t resolve_req(logic [IpW-1:0] ip);
    arp_item_t it;
    it.kind = KIND_RESOLVE;
    it.opcode = OpcW'($urandom());
    it.sender_ip = $urandom();
    it.sender_mac = pick_mac();
    it.target_ip = $urandom();
    it.resolve_ip = ip;
    return it;
  endfunction

  function automatic arp_item_t random_item();
    arp_item_t   it;
    int unsigned sel;
    it = resolve_req(pick_ip());
    if ($urandom_range(0, 99) < 55) begin
      it.kind = KIND_ARP;
      sel = $urandom_range(0, 9);
      if (sel < 5) it.opcode = OPC_REQUEST;
      else if (sel < 8) it.opcode = OpcReply;
      it.sender_ip = pick_ip();
      it.target_ip = ($urandom_range(0, 9) < 7) ? cfg_own_ip : pick_ip();
    end
    return it;
  endfunction

  task automatic queue_item(arp_item_t it);
    arp_items_q.push_back(it);
    items_queued++;
  endtask

  task automatic report_mismatch(string what, logic [81:0] got, logic [81:0] want);
    $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    n_errors++;
  endtask

  task automatic apb_write(input logic [1:0] regsel, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {regsel, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (regsel)
      REG_OWN_IP:  cfg_own_ip = value;
      REG_MASK:    cfg_mask = value;
      REG_NET:     cfg_net = value;
      REG_GATEWAY: cfg_gateway = value;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] own, logic [31:0] mask, logic [31:0] net,
                            logic [31:0] gw);
    apb_write(REG_OWN_IP, own);
    apb_write(REG_MASK, mask);
    apb_write(REG_NET, net);
    apb_write(REG_GATEWAY, gw);
    n_settings++;
  endtask

  // wait for every queued transfer and its result, then let any silent update drain
  task automatic settle();
    while (items_accepted != items_queued || expected_peers_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left <= 0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      predict_arp_outcome(cur_item);
      items_accepted++;
      if ((sender_eager || $urandom_range(0, 4) == 0) && arp_items_q.size() != 0) begin
        cur_item = arp_items_q.pop_front();
        s_axis_tdata <= {cur_item.resolve_ip, cur_item.target_ip, cur_item.sender_mac,
                         cur_item.sender_ip, cur_item.opcode};
        s_axis_tuser <= cur_item.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
        gap_left <= sender_eager ? 0 : $urandom_range(0, 4);
      end
    end else if (!s_axis_tvalid) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (arp_items_q.size() != 0) begin
        cur_item = arp_items_q.pop_front();
        s_axis_tdata <= {cur_item.resolve_ip, cur_item.target_ip, cur_item.sender_mac,
                         cur_item.sender_ip, cur_item.opcode};
        s_axis_tuser <= cur_item.kind;
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    peer_result_t want;
    int unsigned  st;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (expected_peers_q.size() == 0) begin
        report_mismatch("unexpected result", {m_axis_tuser, m_axis_tdata}, '0);
      end else begin
        want = expected_peers_q.pop_front();
        if (m_axis_tuser != want.kind)
          report_mismatch("result_kind", 82'(m_axis_tuser), 82'(want.kind));
        if (m_axis_tdata[MacW-1:0] != want.mac)
          report_mismatch("peer_mac", 82'(m_axis_tdata[MacW-1:0]), 82'(want.mac));
        if (m_axis_tdata[MacW +: IpW] != want.ip)
          report_mismatch("peer_ip", 82'(m_axis_tdata[MacW +: IpW]), 82'(want.ip));
      end
      case (m_axis_tuser)
        RES_REPLY: n_replies++;
        RES_HIT:   n_hits++;
        default:   n_misses++;
      endcase
      results_seen++;
      // long back-pressure now and then so the block fills and stalls its input
      if (results_seen % 150 == 75) st = $urandom_range(60, 100);
      else st = sink_eager ? 0 : $urandom_range(0, 4);
      if (st != 0) begin
        m_axis_tready <= 1'b0;
        stall_left <= st;
      end
    end else if (!m_axis_tready) begin
      if (stall_left > 1) stall_left <= stall_left - 1;
      else begin
        stall_left <= 0;
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [31:0] own, mask, net, gw;
    for (int i = 0; i < CacheEntries; i++) begin
      cache_ip[i] = '0;
      cache_mac[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: all registers zero, every entry holds IP 0
    queue_item(resolve_req(32'h0000_0000));
    queue_item(resolve_req(32'hFFFF_FFFF));
    queue_item(arp_pkt(OPC_REQUEST, 32'h0A00_0005, 48'hAA55_0000_0001, 32'h0000_0000));
    queue_item(resolve_req(32'h0000_0000));
    queue_item(arp_pkt(OpcReply, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 32'h0000_0000));
    queue_item(resolve_req(32'h0000_0000));
    queue_item(arp_pkt(OPC_REQUEST, 32'h0A00_0006, 48'h0200_0000_0006, 32'h0000_0001));
    settle();

    set_config(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0100, 32'hC0A8_0101);
    queue_item(resolve_req(32'h0808_0808));
    queue_item(arp_pkt(OPC_REQUEST, 32'hC0A8_0101, 48'h0200_0000_0101, cfg_own_ip));
    queue_item(resolve_req(32'h0808_0808));
    queue_item(resolve_req(32'hC0A8_0163));
    queue_item(arp_pkt(16'hFFFF, 32'hC0A8_0114, 48'h0200_0000_0114, cfg_own_ip));
    queue_item(arp_pkt(16'h0000, 32'hC0A8_0115, 48'h0000_0000_0000, cfg_own_ip));
    queue_item(resolve_req(32'hC0A8_0114));
    queue_item(arp_pkt(OPC_REQUEST, 32'hC0A8_0114, 48'h5A5A_A5A5_0114, cfg_own_ip));
    queue_item(resolve_req(32'hC0A8_0114));
    queue_item(arp_pkt(OPC_REQUEST, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, cfg_own_ip));
    queue_item(resolve_req(32'hFFFF_FFFF));
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0100, 32'hC0A8_0101);
        1: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        2: set_config(32'h0A00_0001, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        3: set_config(32'h0000_0000, 32'h0000_0000, 32'h0A00_0000, 32'h0A00_00FE);
        4: begin
          mask = 32'hFFFF_FFFF << $urandom_range(2, 24);
          own = $urandom();
          net = own & mask;
          gw = net | 32'd1;
          set_config(own, mask, net, gw);
        end
        default: begin
          mask = $urandom();
          net = $urandom() & mask;
          set_config($urandom(), mask, net, $urandom());
        end
      endcase
      addr_pool[0] = cfg_own_ip;
      addr_pool[1] = cfg_gateway;
      addr_pool[2] = 32'h0000_0000;
      addr_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < 9; i++) addr_pool[i] = cfg_net | (32'($urandom_range(1, 6)) & ~cfg_mask);
      for (int i = 9; i < 12; i++) addr_pool[i] = $urandom();
      sender_eager = (p == 1 || p == 4);
      sink_eager = (p == 2 || p == 4);
      repeat (100) queue_item(random_item());
      settle();
    end

    $display("Run covered %0d transfers in, %0d replies, %0d hits, %0d misses",
             items_accepted, n_replies, n_hits, n_misses);
    $display("across %0d register settings, %0d gateway fallbacks", n_settings, n_gateway);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
